### rtl/fdm_pkg.sv
// ----------------------------------------------------------------------------
// fdm_pkg: shared types and constants
// Widths, command and status codes, and the cell control bundle used by the
// facet dedup and flag merge block.
// ----------------------------------------------------------------------------
`default_nettype none
package fdm_pkg;

  localparam int CAPACITY    = 1024;
  localparam int FACET_NODES = 3;
  localparam int CELLS       = 8;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int ROWS        = CAPACITY / CELLS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int NODE_W      = 24;
  localparam int FLAG_W      = 25;
  localparam int TRI_W       = 3 * NODE_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_READ_OK = 3'd3,
    ST_READ_OR = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FLAG_RD,
    S_FLAG_WR,
    S_NEW,
    S_OUT
  } state_t;

  // control broadcast to every cell
  typedef struct packed {
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  cmp_row;
    logic [CNT_W-1:0]  count;
    logic [TRI_W-1:0]  probe;
    logic              wr_en;
    logic              wr_flag_en;
    logic [CELL_W-1:0] wr_cell;
    logic [ROW_W-1:0]  wr_row;
    logic [TRI_W-1:0]  wr_key;
    logic [TRI_W-1:0]  wr_node;
    logic [FLAG_W-1:0] wr_flag;
  } cell_ctrl_t;

  typedef struct packed {
    logic [TRI_W-1:0]  node;
    logic [FLAG_W-1:0] flag;
  } cell_rd_t;

  // sorted key, packed {hi, mid, lo}
  function automatic logic [TRI_W-1:0] sort_key(input logic [NODE_W-1:0] a,
                                                input logic [NODE_W-1:0] b,
                                                input logic [NODE_W-1:0] c);
    logic [NODE_W-1:0] k0, k1, k2, t;
    k0 = a;
    k1 = b;
    k2 = c;
    if (k0 > k1) begin
      t = k0; k0 = k1; k1 = t;
    end
    if (FACET_NODES == 3) begin
      if (k1 > k2) begin
        t = k1; k1 = k2; k2 = t;
      end
      if (k0 > k1) begin
        t = k0; k0 = k1; k1 = t;
      end
    end
    return {k2, k1, k0};
  endfunction

endpackage
`default_nettype wire

### rtl/fdm_cell.sv
// ----------------------------------------------------------------------------
// fdm_cell: one bank of the survivor table
// Holds every CELLS-th survivor, compares its entry at the scan row with the
// probe key and passes the first hit along the chain.
// ----------------------------------------------------------------------------
`default_nettype none
module fdm_cell (
  input  wire                      clk,
  input  wire  [fdm_pkg::CELL_W-1:0] cell_id,
  input  fdm_pkg::cell_ctrl_t      ctrl,
  input  wire                      hit_in,
  input  wire  [fdm_pkg::CELL_W-1:0] sel_in,
  output logic                     hit_out,
  output logic [fdm_pkg::CELL_W-1:0] sel_out,
  output fdm_pkg::cell_rd_t        rd
);
  import fdm_pkg::*;

  logic [TRI_W-1:0]  key_mem  [ROWS];
  logic [TRI_W-1:0]  node_mem [ROWS];
  logic [FLAG_W-1:0] flag_mem [ROWS];
  logic [TRI_W-1:0]  key_q;
  logic              live;
  logic              match;
  logic              mine;

  assign mine = (ctrl.wr_cell == cell_id);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && mine) begin
      key_mem[ctrl.wr_row]  <= ctrl.wr_key;
      node_mem[ctrl.wr_row] <= ctrl.wr_node;
    end
    if (ctrl.wr_flag_en && mine) begin
      flag_mem[ctrl.wr_row] <= ctrl.wr_flag;
    end
    key_q   <= key_mem[ctrl.rd_row];
    rd.node <= node_mem[ctrl.rd_row];
    rd.flag <= flag_mem[ctrl.rd_row];
  end

  // only entries below the survivor count take part
  assign live  = (CNT_W'({ctrl.cmp_row, cell_id}) < ctrl.count);
  assign match = live && (key_q == ctrl.probe);

  assign hit_out = hit_in | match;
  assign sel_out = hit_in ? sel_in : cell_id;

endmodule
`default_nettype wire

### rtl/facet_dedup_flag_merge_top.sv
// sequence: an insert scans the table row by row, a dropped insert the same;
// a merge stops at the hit row; an out-of-range read skips the table read
// flow: one word at a time; an insert scans the table 8 survivors per
// row, a read state and a compare state per row, so the key memory read port sets the pace
// reset: survivor count cleared, control idle, output word dropped; the table
// memories are not cleared
// ----------------------------------------------------------------------------
// facet_dedup_flag_merge_top: facet dedup with flag merge
// Stores distinct facets by sorted node key and ORs flags of duplicates.
// ----------------------------------------------------------------------------
`default_nettype none
module facet_dedup_flag_merge_top (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // cmd, node_a, node_b, node_c, facet_flag, read_index, zero fill
  input  wire  [111:0] s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // status, survivor_index, out_node_a, out_node_b, out_node_c, merged_flag,
  // survivor_count, zero fill
  output logic [127:0] m_tdata
);
  import fdm_pkg::*;

  state_t state, state_next;

  cmd_t              in_cmd;
  logic [NODE_W-1:0] in_a, in_b, in_c;
  logic [FLAG_W-1:0] in_flag;
  logic [IDX_W-1:0]  in_ridx;
  logic              accept;

  logic [CNT_W-1:0]  count;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  hit_row;
  logic [CELL_W-1:0] hit_cell;
  logic [TRI_W-1:0]  key_q;
  logic [TRI_W-1:0]  node_q;
  logic [FLAG_W-1:0] flag_q;
  logic [IDX_W-1:0]  ridx_q;

  status_t           res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [TRI_W-1:0]  res_node;
  logic [FLAG_W-1:0] res_flag;
  logic [CNT_W-1:0]  res_cnt;

  cell_ctrl_t        ctrl;
  cell_rd_t          rd_bus [CELLS];
  logic              hit [CELLS+1];
  logic [CELL_W-1:0] sel [CELLS+1];

  logic              last_row;
  logic              out_free;
  logic              full;
  logic [FLAG_W-1:0] merged;

  assign in_cmd  = cmd_t'(s_tdata[1:0]);
  assign in_a    = s_tdata[25:2];
  assign in_b    = s_tdata[49:26];
  assign in_c    = (FACET_NODES == 3) ? s_tdata[73:50] : '0;
  assign in_flag = s_tdata[98:74];
  assign in_ridx = s_tdata[108:99];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign last_row = ((CNT_W'({row, CELL_W'(CELLS - 1)}) + CNT_W'(1)) >= count);
  assign merged   = rd_bus[hit_cell].flag | flag_q;

  assign hit[0] = 1'b0;
  assign sel[0] = '0;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    fdm_cell u_cell (
      .clk     (clk),
      .cell_id (CELL_W'(g)),
      .ctrl    (ctrl),
      .hit_in  (hit[g]),
      .sel_in  (sel[g]),
      .hit_out (hit[g+1]),
      .sel_out (sel[g+1]),
      .rd      (rd_bus[g])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_INSERT: state_next = (count == '0) ? S_NEW : S_SCAN_RD;
            CMD_READ:   state_next = (CNT_W'(in_ridx) < count) ? S_RD : S_OUT;
            CMD_CLEAR:  state_next = S_OUT;
            CMD_NONE:   state_next = S_IDLE;
          endcase
        end
      end
      S_RD:       state_next = S_OUT;
      S_SCAN_RD:  state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        priority if (hit[CELLS]) state_next = S_FLAG_RD;
        else if (last_row)       state_next = S_NEW;
        else                     state_next = S_SCAN_RD;
      end
      S_FLAG_RD:  state_next = S_FLAG_WR;
      S_FLAG_WR:  state_next = S_OUT;
      S_NEW:      state_next = S_OUT;
      S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
      default:    state_next = S_IDLE;
    endcase
  end

  // cell control
  always_comb begin
    ctrl            = '0;
    ctrl.count      = count;
    ctrl.probe      = key_q;
    ctrl.cmp_row    = row;
    ctrl.wr_key     = key_q;
    ctrl.wr_node    = node_q;
    ctrl.wr_flag    = flag_q;
    ctrl.wr_row     = count[IDX_W-1:CELL_W];
    ctrl.wr_cell    = count[CELL_W-1:0];
    unique case (state)
      S_IDLE:    ctrl.rd_row = in_ridx[IDX_W-1:CELL_W];
      S_SCAN_RD: ctrl.rd_row = row;
      S_FLAG_RD: ctrl.rd_row = hit_row;
      S_FLAG_WR: begin
        ctrl.wr_flag_en = 1'b1;
        ctrl.wr_row     = hit_row;
        ctrl.wr_cell    = hit_cell;
        ctrl.wr_flag    = merged;
      end
      S_NEW: begin
        ctrl.wr_en      = !full;
        ctrl.wr_flag_en = !full;
      end
      default: ctrl.rd_row = row;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept && in_cmd == CMD_CLEAR) begin
        count <= '0;
      end else if (state == S_NEW && !full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      key_q    <= sort_key(in_a, in_b, in_c);
      node_q   <= {in_c, in_b, in_a};
      flag_q   <= in_flag;
      ridx_q   <= in_ridx;
      row      <= '0;
      res_node <= '0;
      res_flag <= '0;
      if (in_cmd == CMD_CLEAR) begin
        res_status <= ST_CLEARED;
        res_idx    <= '0;
        res_cnt    <= '0;
      end else begin
        res_status <= ST_READ_OR;
        res_idx    <= (in_cmd == CMD_READ) ? in_ridx : '0;
        res_cnt    <= count;
      end
    end
    unique case (state)
      S_RD: begin
        res_status <= ST_READ_OK;
        res_idx    <= ridx_q;
        res_node   <= rd_bus[ridx_q[CELL_W-1:0]].node;
        res_flag   <= rd_bus[ridx_q[CELL_W-1:0]].flag;
      end
      S_SCAN_CMP: begin
        hit_row  <= row;
        hit_cell <= sel[CELLS];
        row      <= row + ROW_W'(1);
      end
      S_FLAG_WR: begin
        res_status <= ST_DUP;
        res_idx    <= IDX_W'({hit_row, hit_cell});
        res_flag   <= merged;
      end
      S_NEW: begin
        if (full) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_NEW;
          res_idx    <= count[IDX_W-1:0];
          res_flag   <= flag_q;
          res_cnt    <= count + CNT_W'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_tdata <= {7'd0, res_cnt, res_flag, res_node, res_idx, res_status};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/fdm_checker.sv
// ----------------------------------------------------------------------------
// fdm_checker: port level checks
// Watches the output channel of the facet dedup block.
// ----------------------------------------------------------------------------
`default_nettype none
module fdm_checker (
  input wire         clk,
  input wire         rst,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire [127:0] m_tdata
);
  import fdm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= 3'(ST_CLEARED))
    else $error("bad status");

  a_new_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == 3'(ST_NEW) |->
      m_tdata[120:110] == CNT_W'(m_tdata[12:3]) + CNT_W'(1))
    else $error("new survivor index does not match count");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == 3'(ST_CLEARED) |-> m_tdata[120:3] == '0)
    else $error("clear word carries data");

endmodule

bind facet_dedup_flag_merge_top fdm_checker u_fdm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
